>>> src/lpcr_pkg.sv
// Shared types and constants for the length-prefixed command ring.
// Used by the front end, the back end sequencer and the top level.
// No dependencies.
package lpcr_pkg;

	// Field widths fixed by the command format
	localparam int WORD_W   = 32;
	localparam int CNT_W    = 3;
	localparam int IN_WORDS = 4;
	localparam int IW_W     = $clog2(IN_WORDS);

	// Largest payload a command may carry or a getter may take
	localparam int MAX_PAYLOAD = 4;

	// Largest value popped_count can report
	localparam int PC_MAX = (2 ** CNT_W) - 1;

	// Operation codes on func
	localparam logic FUNC_POST = 1'b0;
	localparam logic FUNC_GET  = 1'b1;

	// Classified command handed from front to back
	typedef struct packed {
		logic                              func;
		logic [CNT_W-1:0]                  count;
		logic [CNT_W-1:0]                  capacity;
		logic [IN_WORDS-1:0][WORD_W-1:0]   words;
	} cmd_t;

	// One result transaction
	typedef struct packed {
		logic              ok;
		logic [CNT_W-1:0]  popped_count;
		logic              has_word;
		logic [WORD_W-1:0] word;
		logic              last;
	} res_t;

	// Back end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POST_CNT,
		ST_POST_PAY,
		ST_GET_RD,
		ST_GET_CNT,
		ST_GET_EMIT,
		ST_RESULT
	} seq_state_t;

	// Clamp a 3-bit count to the payload limit
	function automatic logic [CNT_W-1:0] sat_payload(input logic [CNT_W-1:0] v);
		logic [CNT_W:0] lim;
		lim = (CNT_W+1)'(MAX_PAYLOAD);
		if ({1'b0, v} > lim) begin
			return lim[CNT_W-1:0];
		end
		return v;
	endfunction

endpackage

>>> src/lpcr_fifo.sv
// Small register-based FIFO used for the command queue and the result queue.
// Depends on nothing but its parameters.
module lpcr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	// Entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> src/lpcr_front.sv
// Front end: accepts input transactions, clamps count and capacity to the
// payload limit and queues the classified command. Uses lpcr_pkg, lpcr_fifo.
module lpcr_front
	import lpcr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                func,
	input  logic [CNT_W-1:0]    count,
	input  logic [CNT_W-1:0]    capacity,
	input  logic [WORD_W-1:0]   word_0,
	input  logic [WORD_W-1:0]   word_1,
	input  logic [WORD_W-1:0]   word_2,
	input  logic [WORD_W-1:0]   word_3,
	output cmd_t                cmd,
	output logic                cmd_valid,
	input  logic                cmd_pop
);

	cmd_t cmd_in;
	logic cmd_empty;

	// Classify: clamp both counts, pack payload
	always_comb begin
		cmd_in.func     = func;
		cmd_in.count    = sat_payload(count);
		cmd_in.capacity = sat_payload(capacity);
		cmd_in.words[0] = word_0;
		cmd_in.words[1] = word_1;
		cmd_in.words[2] = word_2;
		cmd_in.words[3] = word_3;
	end

	// Command queue between front and back
	lpcr_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (2)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd),
		.empty   (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

>>> src/lpcr_back.sv
// Back end: sequencer that owns the ring memory and both cursors, carries
// out posts and gets one word per cycle unless res_full. Uses lpcr_pkg.
module lpcr_back
	import lpcr_pkg::*;
#(
	parameter int RING_LENGTH = 256
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	input  logic  cmd_valid,
	output logic  cmd_pop,
	output res_t  res,
	output logic  res_push,
	input  logic  res_full
);

	localparam int AW    = $clog2(RING_LENGTH);
	localparam int CMP_W = AW + 4;

	typedef logic [AW-1:0] cur_t;

	// Advance a cursor around the ring
	function automatic cur_t step(input cur_t p);
		return (p == AW'(RING_LENGTH - 1)) ? '0 : p + AW'(1);
	endfunction

	seq_state_t       state_q, state_d;
	cur_t             rc_q, rc_d;
	cur_t             wc_q, wc_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] pc_q, pc_d;
	res_t             res_q, res_d;
	cmd_t             cmd_q, cmd_d;

	logic [WORD_W-1:0] ring_q [RING_LENGTH];
	logic [WORD_W-1:0] rd_data_q;
	logic              mem_we;
	logic              mem_re;
	cur_t              mem_addr;
	logic [WORD_W-1:0] mem_wdata;

	cur_t              rc_nx;
	logic [CMP_W-1:0]  post_dist;
	logic [CMP_W-1:0]  get_avail;
	logic              post_ok;
	logic              cnt_skip;
	logic              cnt_fit;
	logic [CNT_W-1:0]  pc_sat;
	logic              emit_last;
	res_t              res_fail;

	// Space and occupancy checks
	always_comb begin
		rc_nx = step(rc_q);
		if (rc_q > wc_q) begin
			post_dist = CMP_W'(rc_q) - CMP_W'(wc_q);
		end else begin
			post_dist = CMP_W'(RING_LENGTH) + CMP_W'(rc_q) - CMP_W'(wc_q);
		end
		if (wc_q >= rc_nx) begin
			get_avail = CMP_W'(wc_q) - CMP_W'(rc_nx);
		end else begin
			get_avail = CMP_W'(RING_LENGTH) + CMP_W'(wc_q) - CMP_W'(rc_nx);
		end
		post_ok   = (CMP_W'(cmd.count) + CMP_W'(1)) < post_dist;
		cnt_skip  = (rd_data_q == '0) || (rd_data_q > WORD_W'(cmd_q.capacity));
		cnt_fit   = CMP_W'(rd_data_q[CNT_W-1:0]) <= get_avail;
		pc_sat    = (rd_data_q > WORD_W'(PC_MAX)) ? CNT_W'(PC_MAX) : rd_data_q[CNT_W-1:0];
		emit_last = (idx_q + CNT_W'(1)) == pc_q;
		res_fail  = '{ok: 1'b0, popped_count: '0, has_word: 1'b0, word: '0, last: 1'b1};
	end

	// Next state and outputs
	always_comb begin
		state_d   = state_q;
		rc_d      = rc_q;
		wc_d      = wc_q;
		idx_d     = idx_q;
		pc_d      = pc_q;
		res_d     = res_q;
		cmd_d     = cmd_q;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		res       = res_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = wc_q;
		mem_wdata = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					cmd_d   = cmd;
					idx_d   = '0;
					if (cmd.func == FUNC_GET) begin
						if (rc_q == wc_q) begin
							res_d   = res_fail;
							state_d = ST_RESULT;
						end else begin
							state_d = ST_GET_RD;
						end
					end else if (post_ok) begin
						state_d = ST_POST_CNT;
					end else begin
						res_d   = res_fail;
						state_d = ST_RESULT;
					end
				end
			end
			// count word of a post
			ST_POST_CNT: begin
				mem_we    = 1'b1;
				mem_addr  = wc_q;
				mem_wdata = WORD_W'(cmd_q.count);
				wc_d      = step(wc_q);
				if (cmd_q.count == '0) begin
					res_d   = '{ok: 1'b1, popped_count: '0, has_word: 1'b0, word: '0,
						last: 1'b1};
					state_d = ST_RESULT;
				end else begin
					state_d = ST_POST_PAY;
				end
			end
			// payload words of a post, one per cycle
			ST_POST_PAY: begin
				mem_we   = 1'b1;
				mem_addr = wc_q;
				if (idx_q < CNT_W'(IN_WORDS)) begin
					mem_wdata = cmd_q.words[idx_q[IW_W-1:0]];
				end
				wc_d  = step(wc_q);
				idx_d = idx_q + CNT_W'(1);
				if ((idx_q + CNT_W'(1)) == cmd_q.count) begin
					res_d   = '{ok: 1'b1, popped_count: '0, has_word: 1'b0, word: '0,
						last: 1'b1};
					state_d = ST_RESULT;
				end
			end
			// fetch the count word
			ST_GET_RD: begin
				mem_re   = 1'b1;
				mem_addr = rc_q;
				state_d  = ST_GET_CNT;
			end
			// decide on the count word, start the first payload read
			ST_GET_CNT: begin
				if (cnt_skip) begin
					rc_d    = rc_nx;
					res_d   = '{ok: 1'b1, popped_count: pc_sat, has_word: 1'b0, word: '0,
						last: 1'b1};
					state_d = ST_RESULT;
				end else if (!cnt_fit) begin
					res_d   = res_fail;
					state_d = ST_RESULT;
				end else begin
					pc_d     = rd_data_q[CNT_W-1:0];
					idx_d    = '0;
					mem_re   = 1'b1;
					mem_addr = rc_nx;
					rc_d     = step(rc_nx);
					state_d  = ST_GET_EMIT;
				end
			end
			// hand out one payload word, fetch the next
			ST_GET_EMIT: begin
				res = '{ok: 1'b1, popped_count: pc_q, has_word: 1'b1, word: rd_data_q,
					last: emit_last};
				if (!res_full) begin
					res_push = 1'b1;
					idx_d    = idx_q + CNT_W'(1);
					if (emit_last) begin
						state_d = ST_IDLE;
					end else begin
						mem_re   = 1'b1;
						mem_addr = rc_q;
						rc_d     = step(rc_q);
					end
				end
			end
			// single result held until the result queue has room
			ST_RESULT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rc_q    <= '0;
			wc_q    <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			rc_q    <= rc_d;
			wc_q    <= wc_d;
			idx_q   <= idx_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pc_q  <= pc_d;
		res_q <= res_d;
		cmd_q <= cmd_d;
	end

	// Single-port ring memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= ring_q[mem_addr];
		end
	end

endmodule

>>> src/length_prefixed_command_ring.sv
// Length-prefixed command ring: a ring of RING_LENGTH 32-bit words in one
// single-port memory holds commands stored as a count word and its payload;
// at most RING_LENGTH-1 words are in use. A post (func 0) gives one result,
// a get (func 1) gives one result per popped payload word, or a single one
// when it fails or pops no words. Both sides look like queues: inputs enter
// a two-deep command queue, results leave through a two-deep result queue.
// Commands are carried out one at a time by a sequencer that makes at most
// one memory access per cycle: a post goes through dispatch, the count word
// write, the payload writes and the result; a get through dispatch, count
// read, count check, then a single result or one emit per payload word,
// which waits while the result queue is full. No clearing pass after reset.
// Uses lpcr_pkg, lpcr_front, lpcr_back, lpcr_fifo.
module length_prefixed_command_ring
	import lpcr_pkg::*;
#(
	parameter int RING_LENGTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                func,
	input  logic [CNT_W-1:0]    count,
	input  logic [CNT_W-1:0]    capacity,
	input  logic [WORD_W-1:0]   word_0,
	input  logic [WORD_W-1:0]   word_1,
	input  logic [WORD_W-1:0]   word_2,
	input  logic [WORD_W-1:0]   word_3,
	output logic                empty,
	input  logic                pop,
	output logic                ok,
	output logic [CNT_W-1:0]    popped_count,
	output logic                has_word,
	output logic [WORD_W-1:0]   word,
	output logic                last
);

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;
	res_t res;
	logic res_push;
	logic res_full;
	res_t res_out;

	// Front end and command queue
	lpcr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.count     (count),
		.capacity  (capacity),
		.word_0    (word_0),
		.word_1    (word_1),
		.word_2    (word_2),
		.word_3    (word_3),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	// Sequencer with the ring memory
	lpcr_back #(
		.RING_LENGTH (RING_LENGTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.res       (res),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	// Result queue
	lpcr_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (2)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign ok           = res_out.ok;
	assign popped_count = res_out.popped_count;
	assign has_word     = res_out.has_word;
	assign word         = res_out.word;
	assign last         = res_out.last;

	// Sequencer never pushes into a full result queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	// A failed transaction is a lone, empty result
	a_fail_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !ok) |-> (popped_count == '0 && !has_word && last && word == '0))
		else $error("failed result carries data");

	// A payload word only comes with a nonzero popped count
	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && has_word) |-> (ok && popped_count != '0))
		else $error("payload word without count");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for length_prefixed_command_ring: directed and random command traffic
// against a behavioral ring predictor, with random idling on both queue sides.
// Depends on lpcr_pkg and the length_prefixed_command_ring RTL.
module testbench;
	import lpcr_pkg::*;

	localparam int RING_LEN       = 256;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 20;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              push         = 1'b0;
	logic              full;
	logic              func         = FUNC_POST;
	logic [CNT_W-1:0]  count        = '0;
	logic [CNT_W-1:0]  capacity     = '0;
	logic [WORD_W-1:0] word_0       = '0;
	logic [WORD_W-1:0] word_1       = '0;
	logic [WORD_W-1:0] word_2       = '0;
	logic [WORD_W-1:0] word_3       = '0;
	logic              empty;
	logic              pop          = 1'b0;
	logic              ok;
	logic [CNT_W-1:0]  popped_count;
	logic              has_word;
	logic [WORD_W-1:0] word;
	logic              last;

	// Predicted ring contents and cursors
	logic [WORD_W-1:0] ring_model [RING_LEN];
	int                rd_pos = 0;
	int                wr_pos = 0;
	res_t              expected_results [$];

	int fail_count      = 0;
	int stall_cycles    = 0;
	int tx_max_gap      = 16;
	int rx_max_gap      = 16;
	int rx_hold_cycles  = 0;

	length_prefixed_command_ring #(
		.RING_LENGTH(RING_LEN)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.count        (count),
		.capacity     (capacity),
		.word_0       (word_0),
		.word_1       (word_1),
		.word_2       (word_2),
		.word_3       (word_3),
		.empty        (empty),
		.pop          (pop),
		.ok           (ok),
		.popped_count (popped_count),
		.has_word     (has_word),
		.word         (word),
		.last         (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------- ring predictor ----------------

	function automatic int next_slot(input int p);
		return (p + 1) % RING_LEN;
	endfunction

	function automatic int ring_fill();
		return (wr_pos - rd_pos + RING_LEN) % RING_LEN;
	endfunction

	function automatic res_t make_result(input logic good, input logic [CNT_W-1:0] pc,
			input logic hw, input logic [WORD_W-1:0] w, input logic fin);
		res_t r;
		r.ok           = good;
		r.popped_count = pc;
		r.has_word     = hw;
		r.word         = w;
		r.last         = fin;
		return r;
	endfunction

	// Apply one accepted command to the predicted ring, queue its results
	task automatic predict_command(input cmd_t c);
		int                n;
		int                start;
		int                lim;
		logic              good;
		logic [WORD_W-1:0] head;
		logic [CNT_W-1:0]  pc;
		logic [WORD_W-1:0] got [MAX_PAYLOAD];
		if (c.func == FUNC_POST) begin
			// count saturates; post rolls back if the write cursor hits the read cursor
			n = (c.count > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(c.count);
			start = wr_pos;
			ring_model[wr_pos] = WORD_W'(n);
			wr_pos = next_slot(wr_pos);
			good = (rd_pos != wr_pos);
			for (int i = 0; good && i < n; i++) begin
				ring_model[wr_pos] = c.words[i];
				wr_pos = next_slot(wr_pos);
				good = (rd_pos != wr_pos);
			end
			if (!good) begin
				wr_pos = start;
			end
			expected_results.push_back(make_result(good, '0, 1'b0, '0, 1'b1));
			return;
		end
		lim = (c.capacity > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(c.capacity);
		if (rd_pos == wr_pos) begin
			expected_results.push_back(make_result(1'b0, '0, 1'b0, '0, 1'b1));
			return;
		end
		start = rd_pos;
		head = ring_model[rd_pos];
		rd_pos = next_slot(rd_pos);
		pc = (head > PC_MAX) ? CNT_W'(PC_MAX) : head[CNT_W-1:0];
		// oversize or empty command: only the count word goes
		if (head > WORD_W'(lim) || head == '0) begin
			expected_results.push_back(make_result(1'b1, pc, 1'b0, '0, 1'b1));
			return;
		end
		n = int'(head);
		for (int i = 0; i < n; i++) begin
			if (rd_pos == wr_pos) begin
				rd_pos = start;
				expected_results.push_back(make_result(1'b0, '0, 1'b0, '0, 1'b1));
				return;
			end
			got[i] = ring_model[rd_pos];
			rd_pos = next_slot(rd_pos);
		end
		for (int i = 0; i < n; i++) begin
			expected_results.push_back(make_result(1'b1, pc, 1'b1, got[i], i == n - 1));
		end
	endtask

	// ---------------- stimulus helpers ----------------

	// Mostly full-range words, sometimes small ones that read back as plausible counts
	function automatic logic [WORD_W-1:0] rand_word();
		if ($urandom_range(0, 3) == 0) begin
			return WORD_W'($urandom_range(0, 7));
		end
		return WORD_W'($urandom);
	endfunction

	function automatic cmd_t post_cmd(input int n, input logic [WORD_W-1:0] w0,
			input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
			input logic [WORD_W-1:0] w3);
		cmd_t c;
		c.func     = FUNC_POST;
		c.count    = CNT_W'(n);
		c.capacity = CNT_W'($urandom_range(0, 7));
		c.words    = {w3, w2, w1, w0};
		return c;
	endfunction

	function automatic cmd_t rand_post(input int lo, input int hi);
		return post_cmd($urandom_range(lo, hi), rand_word(), rand_word(), rand_word(),
			rand_word());
	endfunction

	function automatic cmd_t get_cmd(input int cap);
		cmd_t c;
		c.func     = FUNC_GET;
		c.count    = CNT_W'($urandom_range(0, 7));
		c.capacity = CNT_W'(cap);
		c.words    = {WORD_W'($urandom), WORD_W'($urandom), WORD_W'($urandom),
			WORD_W'($urandom)};
		return c;
	endfunction

	// Offer one command after a random gap; push stays high for a back-to-back follower
	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push     <= 1'b1;
		func     <= c.func;
		count    <= c.count;
		capacity <= c.capacity;
		word_0   <= c.words[0];
		word_1   <= c.words[1];
		word_2   <= c.words[2];
		word_3   <= c.words[3];
		@(posedge clk);
		while (full) @(posedge clk);
		predict_command(c);
	endtask

	task automatic wait_until_drained();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// ---------------- tests ----------------

	// Gets on a freshly reset ring underflow
	task automatic test_empty_get();
		send_cmd(get_cmd(0));
		send_cmd(get_cmd(7));
	endtask

	// Count and capacity up to their largest value of 7, extreme payload words
	task automatic test_post_get_extremes();
		send_cmd(post_cmd(0, '1, '1, '1, '1));
		send_cmd(post_cmd(4, 32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555));
		send_cmd(post_cmd(7, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000));
		send_cmd(post_cmd(1, 32'h0000_0000, '1, '1, '1));
		send_cmd(post_cmd(2, 32'h1234_5678, 32'hFEDC_BA98, '0, '0));
		send_cmd(post_cmd(3, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, '0));
		send_cmd(get_cmd(7));
		send_cmd(get_cmd(4));
		send_cmd(get_cmd(5));
		send_cmd(get_cmd(1));
		send_cmd(get_cmd(2));
		send_cmd(get_cmd(3));
	endtask

	// Skipped command leaves payload words that are then read as counts
	task automatic test_oversize_skip();
		send_cmd(post_cmd(3, 32'd9, 32'hFFFF_FFFF, 32'd2, '0));
		send_cmd(get_cmd(2));
		send_cmd(get_cmd(4));
		send_cmd(get_cmd(4));
		send_cmd(get_cmd(4));
		send_cmd(post_cmd(1, 32'h0000_1234, '0, '0, '0));
		send_cmd(get_cmd(4));
	endtask

	// Result side held off while posts pile up until the ring overflows
	task automatic test_fill_and_stall();
		rx_hold_cycles = 500;
		for (int i = 0; i < 60; i++) begin
			send_cmd(rand_post(3, 7));
		end
		wait_until_drained();
		// full capacity, so each get takes one whole command
		while (ring_fill() != 0) begin
			send_cmd(get_cmd(MAX_PAYLOAD));
		end
		send_cmd(get_cmd($urandom_range(0, 7)));
	endtask

	// Mixed traffic with occupancy swinging between post-heavy and get-heavy phases
	task automatic test_random_traffic();
		int post_pct;
		int cap;
		for (int chunk = 0; chunk < 4; chunk++) begin
			post_pct   = (chunk % 2 == 0) ? 75 : 35;
			tx_max_gap = (chunk == 1) ? 0 : 16;
			rx_max_gap = (chunk == 2) ? 0 : 16;
			for (int i = 0; i < 30; i++) begin
				if ($urandom_range(1, 100) <= post_pct) begin
					send_cmd(rand_post(0, 7));
				end else begin
					cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
					send_cmd(get_cmd(cap));
				end
			end
		end
		tx_max_gap = 16;
		rx_max_gap = 16;
	endtask

	// ---------------- result side ----------------

	// Pop with random gaps; a requested hold-off is counted here
	initial begin : result_drain
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_cycles > 0) begin
				pop <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end else begin
				gap = $urandom_range(0, rx_max_gap);
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	task automatic check_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Compare every result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction: ok=%0b popped_count=%0d word=0x%0h",
					ok, popped_count, word);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("ok", WORD_W'(want.ok), WORD_W'(ok));
				check_field("popped_count", WORD_W'(want.popped_count), WORD_W'(popped_count));
				check_field("has_word", WORD_W'(want.has_word), WORD_W'(has_word));
				check_field("word", want.word, word);
				check_field("last", WORD_W'(want.last), WORD_W'(last));
			end
		end
	end

	// Watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("** length_prefixed_command_ring: FAILED **");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_get();
		test_post_get_extremes();
		test_oversize_skip();
		test_fill_and_stall();
		test_random_traffic();
		wait_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("** length_prefixed_command_ring: PASSED **");
		end else begin
			$display("** length_prefixed_command_ring: FAILED **");
		end
		$finish;
	end

endmodule
